/* sv/epid_pkg.sv */
// ----------------------------------------------------------------------------
// epid_pkg: shared types and sizes for the extreme point engine
// Point sizes, score width, index width and the record that travels from the
// scoring front end through the queue to the selection back end.
// ----------------------------------------------------------------------------
package epid_pkg;

	localparam int DIMS        = 4;
	localparam int MAX_POINTS  = 65536;
	localparam int COORD_BITS  = 16;

	// Port widths fixed by the interface.
	localparam int INDEX_W     = 16;
	localparam int SCORE_OUT_W = 33;

	// Position counter, saturating at MAX_POINTS-1.
	localparam int IDX_BITS    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

	// Exact width of a sum of DIMS signed products.
	localparam int PROD_BITS   = 2 * COORD_BITS;
	localparam int SCORE_BITS  = PROD_BITS + ((DIMS > 1) ? $clog2(DIMS) : 0);

	// Configuration index: one extra bit so that writes past the list are seen
	// and dropped.
	localparam int DIR_SEL_W   = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int CFG_INDEX_W = DIR_SEL_W + 1;

	// Depth of the queue between front and back ends.
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [DIMS-1:0]            coord_vec_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SCORE_BITS-1:0] score_t;
	typedef logic [IDX_BITS-1:0]          pidx_t;

	// One scored point on its way to selection.
	typedef struct packed {
		score_t     score;
		pidx_t      idx;
		logic       first;
		logic       last;
		coord_vec_t coords;
	} epid_entry_t;

endpackage

/* sv/epid_front.sv */
// ----------------------------------------------------------------------------
// epid_front: direction registers, point intake and scoring
// Holds the direction vector, numbers each accepted point, forms the DIMS
// products in one registered stage and hands the summed score to the queue.
// ----------------------------------------------------------------------------
module epid_front
	import epid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  coord_vec_t             in_coords,
	input  logic                   in_last,
	output logic                   q_wr_valid,
	input  logic                   q_wr_ready,
	output epid_entry_t            q_wr_data
);

	coord_t     dir_q [DIMS];
	pidx_t      cnt_q;
	logic       valid_s1;
	prod_t      prod_s1 [DIMS];
	coord_vec_t coord_s1;
	pidx_t      idx_s1;
	logic       first_s1;
	logic       last_s1;
	logic       accept;
	score_t     sum;

	assign in_ready = !valid_s1 || q_wr_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIMS; k++) begin
				dir_q[k] <= '0;
			end
		end else if (cfg_wen && (cfg_index < CFG_INDEX_W'(DIMS))) begin
			dir_q[cfg_index[DIR_SEL_W-1:0]] <= cfg_data;
		end
	end

	// Position of the next point; saturates and restarts after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (in_last) begin
					cnt_q <= '0;
				end else if (cnt_q < IDX_BITS'(MAX_POINTS - 1)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < DIMS; k++) begin
				prod_s1[k] <= in_coords[k] * dir_q[k];
			end
			coord_s1 <= in_coords;
			idx_s1   <= cnt_q;
			first_s1 <= (cnt_q == '0);
			last_s1  <= in_last;
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < DIMS; k++) begin
			sum = sum + score_t'(prod_s1[k]);
		end
	end

	assign q_wr_valid       = valid_s1;
	assign q_wr_data.score  = sum;
	assign q_wr_data.idx    = idx_s1;
	assign q_wr_data.first  = first_s1;
	assign q_wr_data.last   = last_s1;
	assign q_wr_data.coords = coord_s1;

endmodule

/* sv/epid_queue.sv */
// ----------------------------------------------------------------------------
// epid_queue: short FIFO between scoring and selection
// Holds up to QDEPTH scored points so either side can stall on its own.
// ----------------------------------------------------------------------------
module epid_queue
	import epid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	output logic        wr_ready,
	input  epid_entry_t wr_data,
	output logic        rd_valid,
	input  logic        rd_ready,
	output epid_entry_t rd_data
);

	epid_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != (QPTR_W + 1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* sv/epid_back.sv */
// ----------------------------------------------------------------------------
// epid_back: running best selection and result register
// Compares each scored point against the held best, keeps the winner and, on
// the last point of a set, loads the result register and clears for the next.
// ----------------------------------------------------------------------------
module epid_back
	import epid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_rd_valid,
	output logic                   q_rd_ready,
	input  epid_entry_t            q_rd_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [INDEX_W-1:0]     out_index,
	output logic [SCORE_OUT_W-1:0] out_score,
	output coord_vec_t             out_coords
);

	score_t                 best_q;
	pidx_t                  best_idx_q;
	coord_vec_t             best_coord_q;
	logic                   out_valid_q;
	logic [INDEX_W-1:0]     out_index_q;
	logic [SCORE_OUT_W-1:0] out_score_q;
	coord_vec_t             out_coord_q;
	logic                   pop;
	logic                   better;
	score_t                 nxt_best;
	pidx_t                  nxt_idx;
	coord_vec_t             nxt_coord;

	// A point that ends no set can always be folded in; a last point needs
	// room in the result register.
	assign q_rd_ready = !q_rd_data.last || !out_valid_q || out_ready;
	assign pop        = q_rd_valid && q_rd_ready;

	always_comb begin
		better    = (q_rd_data.score > best_q);
		nxt_best  = better ? q_rd_data.score : best_q;
		nxt_idx   = better ? q_rd_data.idx : best_idx_q;
		nxt_coord = (better || q_rd_data.first) ? q_rd_data.coords : best_coord_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (q_rd_data.last) begin
					best_q     <= '0;
					best_idx_q <= '0;
				end else begin
					best_q     <= nxt_best;
					best_idx_q <= nxt_idx;
				end
			end
			if (pop && q_rd_data.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			best_coord_q <= nxt_coord;
			if (q_rd_data.last) begin
				out_index_q <= INDEX_W'(nxt_idx);
				out_score_q <= SCORE_OUT_W'(nxt_best);
				out_coord_q <= nxt_coord;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign out_score  = out_score_q;
	assign out_coords = out_coord_q;

endmodule

/* sv/extreme_point_in_direction_top.sv */
// ----------------------------------------------------------------------------
// extreme_point_in_direction_top: support point of a streamed point set
// Scores each point against a programmed direction and reports the point with
// the largest dot product when the last point of a set arrives.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle, sustained, as long as results are
// taken when offered. Each request carries DIMS signed Q1.14 coordinates and a
// last_point flag. The front end multiplies the point by the direction vector
// (dir_0..dir_3, written through cfg_wen/cfg_index/cfg_data while the block is
// idle) in one registered stage and pushes the exact Q5.28 score into a
// four-entry queue. The back end pops one scored point per cycle (a last point
// only while the result register has room), keeps the running best (starting
// at zero with index 0; only a strictly greater score replaces it, so with no
// positive score the first point of the set wins) and, on the last point, loads
// the result register and clears for the next set. A result is offered once its
// last point has passed, in order, through the product register, the queue and
// the result register. While a result waits in the output register, points that
// do not end a set keep flowing; a second last point waits in the queue until the
// pending result is taken. Point positions saturate at MAX_POINTS-1, and writes
// to indexes past the direction list are dropped.
// ----------------------------------------------------------------------------
module extreme_point_in_direction_top
	import epid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     coord_0,
	input  logic signed [15:0]     coord_1,
	input  logic signed [15:0]     coord_2,
	input  logic signed [15:0]     coord_3,
	input  logic                   last_point,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            best_index,
	output logic [32:0]            best_score,
	output logic signed [15:0]     best_coord_0,
	output logic signed [15:0]     best_coord_1,
	output logic signed [15:0]     best_coord_2,
	output logic signed [15:0]     best_coord_3
);

	coord_vec_t  in_coords;
	coord_vec_t  out_coords;
	logic        q_wr_valid;
	logic        q_wr_ready;
	epid_entry_t q_wr_data;
	logic        q_rd_valid;
	logic        q_rd_ready;
	epid_entry_t q_rd_data;

	assign in_coords[0] = coord_0;
	assign in_coords[1] = coord_1;
	assign in_coords[2] = coord_2;
	assign in_coords[3] = coord_3;

	// Front end: direction registers, point numbering and products.
	epid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_coords  (in_coords),
		.in_last    (last_point),
		.q_wr_valid (q_wr_valid),
		.q_wr_ready (q_wr_ready),
		.q_wr_data  (q_wr_data)
	);

	// Decoupling queue between scoring and selection.
	epid_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data)
	);

	// Back end: running best and result register.
	epid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rd_valid (q_rd_valid),
		.q_rd_ready (q_rd_ready),
		.q_rd_data  (q_rd_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_index  (best_index),
		.out_score  (best_score),
		.out_coords (out_coords)
	);

	assign best_coord_0 = out_coords[0];
	assign best_coord_1 = out_coords[1];
	assign best_coord_2 = out_coords[2];
	assign best_coord_3 = out_coords[3];

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for extreme_point_in_direction_top
// Streams point sets through the block under several programmed directions
// and compares every reported winner, field by field, with a scoring model
// kept inside the bench. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import epid_pkg::*;

	localparam int RESET_CYCLES     = 4;
	localparam int MAX_WAIT         = 18;
	// Idle cycles allowed after the last result before the block is treated as
	// quiet. The datapath is three stages deep, so this leaves a wide margin.
	localparam int SETTLE_CYCLES    = 12;
	localparam int RANDOM_PHASES    = 7;
	localparam int POINTS_PER_PHASE = 250;
	localparam int LIMIT_NS         = 2000000;

	typedef logic [CFG_INDEX_W-1:0] reg_index_t;

	// Register map: one register per direction component, the rest unused.
	localparam reg_index_t DIR_0 = 0;
	localparam reg_index_t DIR_1 = 1;
	localparam reg_index_t DIR_2 = 2;
	localparam reg_index_t DIR_3 = 3;
	localparam int FIRST_SPARE_INDEX = DIMS;
	localparam int LAST_SPARE_INDEX  = (1 << CFG_INDEX_W) - 1;

	localparam coord_t COORD_MIN = -32768;
	localparam coord_t COORD_MAX = 32767;

	// One point request and one reported winner.
	typedef struct packed {
		coord_vec_t c;
		logic       last;
	} point_t;

	typedef struct packed {
		logic [INDEX_W-1:0]     idx;
		logic [SCORE_OUT_W-1:0] score;
		coord_vec_t             c;
	} winner_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_wen    = 1'b0;
	reg_index_t             cfg_index  = '0;
	logic [COORD_BITS-1:0]  cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic signed [15:0]     coord_0    = '0;
	logic signed [15:0]     coord_1    = '0;
	logic signed [15:0]     coord_2    = '0;
	logic signed [15:0]     coord_3    = '0;
	logic                   last_point = 1'b0;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [15:0]            best_index;
	logic [32:0]            best_score;
	logic signed [15:0]     best_coord_0;
	logic signed [15:0]     best_coord_1;
	logic signed [15:0]     best_coord_2;
	logic signed [15:0]     best_coord_3;

	// Requests waiting to be sent, and winners waiting to be reported.
	point_t  point_queue[$];
	winner_t expected_winners[$];

	// Scoring model state: the programmed direction and the set in progress.
	coord_vec_t direction   = '0;
	longint     lead_score  = 0;
	int         lead_pos    = 0;
	coord_vec_t lead_coords = '0;
	int         set_pos     = 0;

	// Sender and receiver pacing.
	point_t in_flight;
	int     send_wait    = 0;
	bit     send_burst   = 1'b0;
	int     stall_left   = 0;
	bit     recv_burst   = 1'b0;

	int error_count        = 0;
	int results_seen       = 0;
	int points_sent        = 0;
	int direction_settings = 0;

	extreme_point_in_direction_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.coord_0      (coord_0),
		.coord_1      (coord_1),
		.coord_2      (coord_2),
		.coord_3      (coord_3),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.best_index   (best_index),
		.best_score   (best_score),
		.best_coord_0 (best_coord_0),
		.best_coord_1 (best_coord_1),
		.best_coord_2 (best_coord_2),
		.best_coord_3 (best_coord_3)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Scores one accepted point against the current direction. The exact dot
	// product of four 16-bit pairs fits easily in 64 bits. The lead starts at
	// zero, so only a strictly positive and strictly better score takes over;
	// the first point of a set is the fallback winner. On the last point the
	// winner is queued for comparison and the set state clears.
	function automatic void score_point(input point_t p);
		longint dot;
		dot = 0;
		for (int k = 0; k < DIMS; k++)
			dot += longint'(signed'(p.c[k])) * longint'(signed'(direction[k]));
		if (set_pos == 0)
			lead_coords = p.c;
		if (dot > lead_score) begin
			lead_score  = dot;
			lead_pos    = set_pos;
			lead_coords = p.c;
		end
		// Positions stop counting at the top of the index range.
		if (set_pos < MAX_POINTS - 1)
			set_pos++;
		if (p.last) begin
			expected_winners.push_back('{idx: lead_pos[INDEX_W-1:0],
				score: lead_score[SCORE_OUT_W-1:0], c: lead_coords});
			lead_score  = 0;
			lead_pos    = 0;
			lead_coords = '0;
			set_pos     = 0;
		end
	endfunction

	// Compares one reported winner with the oldest one expected.
	function automatic void check_winner(input winner_t got);
		winner_t want;
		results_seen++;
		if (expected_winners.size() == 0) begin
			$display("%0t: unexpected result: index %0d score %0d", $time, got.idx,
				got.score);
			error_count++;
			return;
		end
		want = expected_winners.pop_front();
		if (got.idx !== want.idx) begin
			$display("%0t: best_index expected %0d actual %0d", $time, want.idx, got.idx);
			error_count++;
		end
		if (got.score !== want.score) begin
			$display("%0t: best_score expected %0d actual %0d", $time, want.score,
				got.score);
			error_count++;
		end
		for (int k = 0; k < DIMS; k++) begin
			if (got.c[k] !== want.c[k]) begin
				$display("%0t: best_coord_%0d expected %0d actual %0d", $time, k,
					signed'(want.c[k]), signed'(got.c[k]));
				error_count++;
			end
		end
	endfunction

	// Coordinates lean toward the extremes and zero, with a band of small
	// values so that ties and near ties come up often.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return coord_t'(int'($urandom_range(0, 64)) - 32);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic void add_point(input coord_t c0, input coord_t c1,
		input coord_t c2, input coord_t c3, input bit last);
		point_t p;
		p.c[0] = c0;
		p.c[1] = c1;
		p.c[2] = c2;
		p.c[3] = c3;
		p.last = last;
		point_queue.push_back(p);
	endfunction

	// One register write, issued at the rising edge. Writes past the direction
	// list are dropped by the block, so the model ignores them too.
	task automatic write_reg(input reg_index_t idx, input coord_t val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx < DIMS)
			direction[idx] = val;
	endtask

	// Programs a full direction, then pokes one unused index with junk to show
	// that it changes nothing.
	task automatic set_direction(input coord_t d0, input coord_t d1,
		input coord_t d2, input coord_t d3);
		write_reg(DIR_0, d0);
		write_reg(DIR_1, d1);
		write_reg(DIR_2, d2);
		write_reg(DIR_3, d3);
		write_reg(reg_index_t'($urandom_range(FIRST_SPARE_INDEX, LAST_SPARE_INDEX)),
			coord_t'($urandom()));
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
		direction_settings++;
	endtask

	// Waits until every request is sent and every winner reported, then lets
	// the pipeline run empty before anything is reprogrammed.
	task automatic drain();
		do
			@(negedge clk);
		while (point_queue.size() != 0 || in_valid || expected_winners.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Request driver. A presented point stays on the bus until it is taken.
	// After each accepted point the sender draws its pause before the next one;
	// now and then it flips into a burst mode with no pauses at all.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			coord_0    <= '0;
			coord_1    <= '0;
			coord_2    <= '0;
			coord_3    <= '0;
			last_point <= 1'b0;
			send_wait  = 0;
		end else begin
			if (in_valid && in_ready) begin
				score_point(in_flight);
				points_sent++;
				if ($urandom_range(0, 49) == 0)
					send_burst = !send_burst;
				send_wait = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (point_queue.size() > 0) begin
					in_flight = point_queue.pop_front();
					coord_0    <= in_flight.c[0];
					coord_1    <= in_flight.c[1];
					coord_2    <= in_flight.c[2];
					coord_3    <= in_flight.c[3];
					last_point <= in_flight.last;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every accepted winner is checked, after which the
	// receiver draws how long it holds off the next one. Bursts with no
	// stalling come and go the same way as on the sending side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_winner('{idx: best_index, score: best_score,
					c: {best_coord_3, best_coord_2, best_coord_1, best_coord_0}});
				if ($urandom_range(0, 49) == 0)
					recv_burst = !recv_burst;
				stall_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	initial begin : stimulus
		point_t p;
		int     n;
		int     len;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// The direction is still zero after reset: every score is zero, so the
		// first point of the set wins with a zero score.
		add_point(1234, -5, 32767, -32768, 1'b0);
		add_point(-32768, 32767, 1, -1, 1'b0);
		add_point(7, 7, 7, 7, 1'b1);
		drain();

		// Unit direction along the first axis.
		set_direction(16384, 0, 0, 0);
		// An equal score must not displace the point already holding the lead.
		add_point(1000, 1, 2, 3, 1'b0);
		add_point(1000, -9, 9, -9, 1'b0);
		add_point(-5, 0, 0, 0, 1'b1);
		// Nothing positive: zero score, first point reported.
		add_point(-1, 100, 100, 100, 1'b0);
		add_point(-32768, 0, 0, 0, 1'b1);
		// Steadily rising scores: the last point itself wins.
		add_point(1, 0, 0, 0, 1'b0);
		add_point(2, 0, 0, 0, 1'b0);
		add_point(3, 0, 0, 0, 1'b1);
		// Sets of a single point, winning and losing.
		add_point(32767, 0, 0, 0, 1'b1);
		add_point(-32768, 5, 5, 5, 1'b1);
		drain();

		// Most negative direction: the all-minimum point gives the largest score
		// the block can report, and a repeat of it is a tie that must not win.
		set_direction(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		add_point(32767, 32767, 32767, 32767, 1'b0);
		add_point(-32768, -32768, -32768, -32768, 1'b0);
		add_point(-32768, -32768, -32768, -32768, 1'b0);
		add_point(0, 0, 0, 0, 1'b1);
		drain();

		set_direction(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		add_point(32767, 32767, 32767, 32767, 1'b0);
		add_point(32767, -32768, 0, 1, 1'b1);
		drain();

		// Mixed signs in the direction.
		set_direction(COORD_MAX, COORD_MIN, 1, -1);
		add_point(-32768, 32767, -32768, 32767, 1'b0);
		add_point(32767, -32768, 32767, -32768, 1'b1);
		drain();

		// Random sets under a series of directions. Most sets are short so that
		// many winners come back; some are longer, and now and then a point is
		// repeated to force a tie inside the set.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: set_direction(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
				1: set_direction(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
				2: set_direction(0, 16384, 0, -16384);
				default: set_direction(pick_coord(), pick_coord(), pick_coord(),
					pick_coord());
			endcase
			n = 0;
			while (n < POINTS_PER_PHASE) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if (i == 0 || $urandom_range(0, 5) != 0) begin
						for (int k = 0; k < DIMS; k++)
							p.c[k] = pick_coord();
					end
					p.last = (i == len - 1);
					point_queue.push_back(p);
				end
				n += len;
			end
			drain();
		end

		$display("testbench: %0d points accepted, %0d winners compared", points_sent,
			results_seen);
		$display("testbench: %0d direction settings, with ties, all-negative sets and",
			direction_settings);
		$display("testbench: single-point sets under random stalls on both sides");
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Hard stop in case the handshake hangs.
	initial begin : watchdog
		#(LIMIT_NS);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
